/* rtl/core/bsr_pkg.sv */
// Shared types and constants for the block-sparse-row matrix-vector engine.
package bsr_pkg;

  localparam int ACTION_W = 2;
  localparam int BIDX_W   = 10;
  localparam int OFS_W    = 3;
  localparam int VIDX_W   = 10;
  localparam int X_W      = 32;
  localparam int Y_W      = 48;
  localparam int PROD_W   = 2 * X_W;
  localparam int FRAC_W   = 16;
  localparam int NROWS_W  = 11;
  localparam int BDIM_W   = 4;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 2;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic signed [Y_W-1:0] yval_t;

  localparam action_t ACT_LOAD_X = 2'd0;
  localparam action_t ACT_ACCUM  = 2'd1;
  localparam action_t ACT_READ_Y = 2'd2;

  localparam cfg_idx_t CFG_NUM_ROWS     = 2'd0;
  localparam cfg_idx_t CFG_BLOCK_HEIGHT = 2'd1;
  localparam cfg_idx_t CFG_BLOCK_WIDTH  = 2'd2;

  localparam logic [NROWS_W-1:0] NUM_ROWS_RST = 11'd1024;
  localparam logic [BDIM_W-1:0]  BDIM_RST     = 4'd1;

  localparam yval_t Y_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam yval_t Y_MIN = 48'sh8000_0000_0000;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = 64'sd32768;

endpackage

/* rtl/core/bsr_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module bsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/bsr_sparse_matvec_accumulate_top.sv */
// Top level of the block-sparse-row matrix-vector multiply-accumulate engine.
// Timing: an item is taken when start is high and busy is low, and busy stays
// high until the item is finished. An x load is written in CALC; a matrix
// element goes through CALC (address and range check, x and y read), MUL
// (multiply), RND (rounding) and ADD (saturating add, y write back); a y read
// goes through CALC and YRD, which zeroes the entry, with its result on
// row_index, y_value and range_error for the single cycle in which done is
// high; an out-of-range read reports from CALC. These steps come from the
// read-modify-write of y through one RAM with a registered read. After reset
// the y RAM is swept to zero, one entry a cycle, over all MAX_ROWS entries
// while busy is high; configuration writes are taken at any time. The result
// side cannot stall, so take each result in the cycle in which done is high.
module bsr_sparse_matvec_accumulate_top #(
  parameter int MAX_ROWS      = 1024,
  parameter int MAX_BLOCK_DIM = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_write,
  input  bsr_pkg::cfg_idx_t             cfg_index,
  input  logic [bsr_pkg::CFG_W-1:0]     cfg_data,
  input  bsr_pkg::action_t              action,
  input  logic [bsr_pkg::BIDX_W-1:0]    blk_row,
  input  logic [bsr_pkg::BIDX_W-1:0]    block_col,
  input  logic [bsr_pkg::OFS_W-1:0]     row_in_block,
  input  logic [bsr_pkg::OFS_W-1:0]     col_in_block,
  input  logic [bsr_pkg::VIDX_W-1:0]    vec_index,
  input  logic signed [bsr_pkg::X_W-1:0] value,
  output logic                          done,
  output logic [bsr_pkg::VIDX_W-1:0]    row_index,
  output bsr_pkg::yval_t                y_value,
  output logic                          range_error
);

  localparam int AW     = $clog2(MAX_ROWS);
  localparam int NW_MIN = $clog2(MAX_ROWS + 1);
  localparam int NW     = (NW_MIN > bsr_pkg::NROWS_W) ? NW_MIN : bsr_pkg::NROWS_W;
  localparam int DW_MIN = $clog2(MAX_BLOCK_DIM + 1);
  localparam int DW     = (DW_MIN > bsr_pkg::BDIM_W) ? DW_MIN : bsr_pkg::BDIM_W;
  localparam int RW     = bsr_pkg::BIDX_W + DW + 1;
  localparam int CMPW   = (RW > NW) ? RW : NW;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CALC  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_RND   = 3'd4;
  localparam logic [2:0] ST_ADD   = 3'd5;
  localparam logic [2:0] ST_YRD   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [AW-1:0] clr_addr;
  logic err_flag;

  logic [bsr_pkg::NROWS_W-1:0] num_rows;
  logic [bsr_pkg::BDIM_W-1:0]  block_height;
  logic [bsr_pkg::BDIM_W-1:0]  block_width;

  bsr_pkg::action_t             act_q;
  logic [bsr_pkg::BIDX_W-1:0]   brow_q;
  logic [bsr_pkg::BIDX_W-1:0]   bcol_q;
  logic [bsr_pkg::OFS_W-1:0]    rin_q;
  logic [bsr_pkg::OFS_W-1:0]    cin_q;
  logic [bsr_pkg::VIDX_W-1:0]   vidx_q;
  logic signed [bsr_pkg::X_W-1:0] val_q;

  logic [AW-1:0] row_addr;
  logic signed [bsr_pkg::PROD_W-1:0] prod;
  bsr_pkg::yval_t rounded;
  bsr_pkg::yval_t y_old;

  logic [NW-1:0]   n_eff;
  logic [DW-1:0]   r_eff;
  logic [DW-1:0]   c_eff;
  logic [CMPW-1:0] row_full;
  logic [CMPW-1:0] col_full;
  logic [CMPW-1:0] vidx_full;
  logic            elem_ok;
  logic            vidx_ok;
  logic signed [bsr_pkg::PROD_W-1:0] prod_rnd;
  logic signed [bsr_pkg::Y_W:0]      sum_wide;
  bsr_pkg::yval_t                    sum_sat;

  logic                       x_we;
  logic [AW-1:0]              x_waddr;
  logic                       x_re;
  logic [AW-1:0]              x_raddr;
  logic [bsr_pkg::X_W-1:0]    x_rdata;
  logic                       y_we;
  logic [AW-1:0]              y_waddr;
  logic [bsr_pkg::Y_W-1:0]    y_wdata;
  logic                       y_re;
  logic [AW-1:0]              y_raddr;
  logic [bsr_pkg::Y_W-1:0]    y_rdata;

  assign busy = (state != ST_IDLE);

  always_comb begin
    if (num_rows == '0) begin
      n_eff = NW'(1);
    end else if (NW'(num_rows) > NW'(MAX_ROWS)) begin
      n_eff = NW'(MAX_ROWS);
    end else begin
      n_eff = NW'(num_rows);
    end
    if (block_height == '0) begin
      r_eff = DW'(1);
    end else if (DW'(block_height) > DW'(MAX_BLOCK_DIM)) begin
      r_eff = DW'(MAX_BLOCK_DIM);
    end else begin
      r_eff = DW'(block_height);
    end
    if (block_width == '0) begin
      c_eff = DW'(1);
    end else if (DW'(block_width) > DW'(MAX_BLOCK_DIM)) begin
      c_eff = DW'(MAX_BLOCK_DIM);
    end else begin
      c_eff = DW'(block_width);
    end
  end

  always_comb begin
    row_full  = CMPW'(RW'(brow_q) * RW'(r_eff) + RW'(rin_q));
    col_full  = CMPW'(RW'(bcol_q) * RW'(c_eff) + RW'(cin_q));
    vidx_full = CMPW'(vidx_q);
    vidx_ok   = vidx_full < CMPW'(n_eff);
    elem_ok   = (DW'(rin_q) < r_eff) && (DW'(cin_q) < c_eff) &&
                (row_full < CMPW'(n_eff)) && (col_full < CMPW'(n_eff));
  end

  always_comb begin
    prod_rnd = prod + bsr_pkg::ROUND_HALF;
    sum_wide = {y_old[bsr_pkg::Y_W-1], y_old} + {rounded[bsr_pkg::Y_W-1], rounded};
    if (sum_wide[bsr_pkg::Y_W] != sum_wide[bsr_pkg::Y_W-1]) begin
      sum_sat = sum_wide[bsr_pkg::Y_W] ? bsr_pkg::Y_MIN : bsr_pkg::Y_MAX;
    end else begin
      sum_sat = sum_wide[bsr_pkg::Y_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    x_we    = 1'b0;
    x_waddr = vidx_full[AW-1:0];
    x_re    = 1'b0;
    x_raddr = col_full[AW-1:0];
    y_we    = 1'b0;
    y_waddr = row_addr;
    y_wdata = sum_sat;
    y_re    = 1'b0;
    y_raddr = row_full[AW-1:0];
    unique case (state)
      ST_CLEAR: begin
        y_we    = 1'b1;
        y_waddr = clr_addr;
        y_wdata = '0;
        if (clr_addr == AW'(MAX_ROWS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        state_next = ST_IDLE;
        case (act_q)
          bsr_pkg::ACT_LOAD_X: begin
            x_we = vidx_ok;
          end
          bsr_pkg::ACT_ACCUM: begin
            if (elem_ok) begin
              x_re       = 1'b1;
              y_re       = 1'b1;
              state_next = ST_MUL;
            end
          end
          bsr_pkg::ACT_READ_Y: begin
            if (vidx_ok) begin
              y_re       = 1'b1;
              y_raddr    = vidx_full[AW-1:0];
              state_next = ST_YRD;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_MUL: begin
        state_next = ST_RND;
      end
      ST_RND: begin
        state_next = ST_ADD;
      end
      ST_ADD: begin
        y_we       = 1'b1;
        state_next = ST_IDLE;
      end
      ST_YRD: begin
        y_we       = 1'b1;
        y_waddr    = vidx_full[AW-1:0];
        y_wdata    = '0;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      err_flag     <= 1'b0;
      done         <= 1'b0;
      num_rows     <= bsr_pkg::NUM_ROWS_RST;
      block_height <= bsr_pkg::BDIM_RST;
      block_width  <= bsr_pkg::BDIM_RST;
    end else begin
      state <= state_next;
      done  <= (state == ST_YRD) ||
               (state == ST_CALC && act_q == bsr_pkg::ACT_READ_Y && !vidx_ok);
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg_write) begin
        unique case (cfg_index)
          bsr_pkg::CFG_NUM_ROWS:     num_rows     <= cfg_data[bsr_pkg::NROWS_W-1:0];
          bsr_pkg::CFG_BLOCK_HEIGHT: block_height <= cfg_data[bsr_pkg::BDIM_W-1:0];
          bsr_pkg::CFG_BLOCK_WIDTH:  block_width  <= cfg_data[bsr_pkg::BDIM_W-1:0];
          default: ;
        endcase
      end
      if (state == ST_CALC) begin
        case (act_q)
          bsr_pkg::ACT_LOAD_X: begin
            if (!vidx_ok) begin
              err_flag <= 1'b1;
            end
          end
          bsr_pkg::ACT_ACCUM: begin
            if (!elem_ok) begin
              err_flag <= 1'b1;
            end
          end
          bsr_pkg::ACT_READ_Y: begin
            if (!vidx_ok) begin
              err_flag <= 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Payload registers: capture on accept, compute through the element states
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      act_q  <= action;
      brow_q <= blk_row;
      bcol_q <= block_col;
      rin_q  <= row_in_block;
      cin_q  <= col_in_block;
      vidx_q <= vec_index;
      val_q  <= value;
    end
    if (state == ST_CALC) begin
      row_addr <= row_full[AW-1:0];
      if (act_q == bsr_pkg::ACT_READ_Y && !vidx_ok) begin
        row_index   <= vidx_q;
        y_value     <= '0;
        range_error <= 1'b1;
      end
    end
    if (state == ST_MUL) begin
      prod  <= val_q * $signed(x_rdata);
      y_old <= $signed(y_rdata);
    end
    if (state == ST_RND) begin
      rounded <= prod_rnd[bsr_pkg::PROD_W-1 -: bsr_pkg::Y_W];
    end
    if (state == ST_YRD) begin
      row_index   <= vidx_q;
      y_value     <= $signed(y_rdata);
      range_error <= err_flag;
    end
  end

  bsr_ram #(
    .WIDTH(bsr_pkg::X_W),
    .DEPTH(MAX_ROWS)
  ) u_x_ram (
    .clk  (clk),
    .we   (x_we),
    .waddr(x_waddr),
    .wdata(val_q),
    .re   (x_re),
    .raddr(x_raddr),
    .rdata(x_rdata)
  );

  bsr_ram #(
    .WIDTH(bsr_pkg::Y_W),
    .DEPTH(MAX_ROWS)
  ) u_y_ram (
    .clk  (clk),
    .we   (y_we),
    .waddr(y_waddr),
    .wdata(y_wdata),
    .re   (y_re),
    .raddr(y_raddr),
    .rdata(y_rdata)
  );

endmodule

/* test/tb_bsr_sparse_matvec_accumulate_top.sv */
// Self-checking testbench for the block-sparse-row matrix-vector engine.
`timescale 1ns / 1ps

module tb_bsr_sparse_matvec_accumulate_top;

  localparam int MAX_ROWS      = 1024;
  localparam int MAX_BLOCK_DIM = 8;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int PHASE_ITEMS   = 150;
  localparam int NUM_PHASES    = 9;
  localparam int SETTLE_CYCLES = 8;

  localparam bsr_pkg::action_t ACT_RESERVED = 2'd3;

  typedef struct packed {
    bsr_pkg::action_t                action;
    logic [bsr_pkg::BIDX_W-1:0]      blk_row;
    logic [bsr_pkg::BIDX_W-1:0]      block_col;
    logic [bsr_pkg::OFS_W-1:0]       row_in_block;
    logic [bsr_pkg::OFS_W-1:0]       col_in_block;
    logic [bsr_pkg::VIDX_W-1:0]      vec_index;
    logic [bsr_pkg::X_W-1:0]         value;
  } cmd_t;

  typedef struct packed {
    logic [bsr_pkg::VIDX_W-1:0] row_index;
    logic [bsr_pkg::Y_W-1:0]    y_value;
    logic                       range_error;
  } yread_t;

  typedef struct packed {
    logic                      is_cfg;
    bsr_pkg::cfg_idx_t         idx;
    logic [bsr_pkg::CFG_W-1:0] data;
    cmd_t                      cmd;
    logic                      fixed;
    yread_t                    want;
  } step_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic                           busy;
  logic                           cfg_write = 1'b0;
  bsr_pkg::cfg_idx_t              cfg_index = bsr_pkg::CFG_NUM_ROWS;
  logic [bsr_pkg::CFG_W-1:0]      cfg_data = '0;
  bsr_pkg::action_t               action = bsr_pkg::ACT_LOAD_X;
  logic [bsr_pkg::BIDX_W-1:0]     blk_row = '0;
  logic [bsr_pkg::BIDX_W-1:0]     block_col = '0;
  logic [bsr_pkg::OFS_W-1:0]      row_in_block = '0;
  logic [bsr_pkg::OFS_W-1:0]      col_in_block = '0;
  logic [bsr_pkg::VIDX_W-1:0]     vec_index = '0;
  logic signed [bsr_pkg::X_W-1:0] value = '0;
  logic                           done;
  logic [bsr_pkg::VIDX_W-1:0]     row_index;
  bsr_pkg::yval_t                 y_value;
  logic                           range_error;

  bsr_sparse_matvec_accumulate_top #(
    .MAX_ROWS      (MAX_ROWS),
    .MAX_BLOCK_DIM (MAX_BLOCK_DIM)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .action       (action),
    .blk_row      (blk_row),
    .block_col    (block_col),
    .row_in_block (row_in_block),
    .col_in_block (col_in_block),
    .vec_index    (vec_index),
    .value        (value),
    .done         (done),
    .row_index    (row_index),
    .y_value      (y_value),
    .range_error  (range_error)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [bsr_pkg::NROWS_W-1:0]    num_rows_q;
  logic [bsr_pkg::BDIM_W-1:0]     height_q;
  logic [bsr_pkg::BDIM_W-1:0]     width_q;
  logic signed [bsr_pkg::X_W-1:0] x_mirror [MAX_ROWS];
  logic                           x_loaded [MAX_ROWS];
  logic signed [bsr_pkg::Y_W-1:0] y_mirror [MAX_ROWS];
  logic                           err_mirror;

  yread_t expected_reads [$];
  int     mismatches = 0;
  int     cycles;

  int phase_rows   [NUM_PHASES] = '{1024, 16, 1, 0, 2047, 64, 100, 8, 1000};
  int phase_height [NUM_PHASES] = '{1, 8, 1, 0, 15, 3, 8, 2, 7};
  int phase_width  [NUM_PHASES] = '{1, 8, 1, 0, 15, 5, 2, 4, 6};

  function automatic int eff_dim(int v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic void reset_mirror();
    num_rows_q = bsr_pkg::NUM_ROWS_RST;
    height_q   = bsr_pkg::BDIM_RST;
    width_q    = bsr_pkg::BDIM_RST;
    err_mirror = 1'b0;
    for (int k = 0; k < MAX_ROWS; k++) begin
      x_mirror[k] = '0;
      x_loaded[k] = 1'b0;
      y_mirror[k] = '0;
    end
  endfunction

  function automatic bit elem_in_range(input cmd_t c, output int row, output int col);
    int n, rh, cw;
    n   = eff_dim(num_rows_q, MAX_ROWS);
    rh  = eff_dim(height_q, MAX_BLOCK_DIM);
    cw  = eff_dim(width_q, MAX_BLOCK_DIM);
    row = int'(c.blk_row) * rh + int'(c.row_in_block);
    col = int'(c.block_col) * cw + int'(c.col_in_block);
    return !(int'(c.row_in_block) >= rh || int'(c.col_in_block) >= cw ||
             row >= n || col >= n);
  endfunction

  function automatic bit apply_cmd(input cmd_t c, output yread_t res);
    int                 n, row, col;
    logic signed [63:0] prod, rnd, sum;
    n   = eff_dim(num_rows_q, MAX_ROWS);
    res = '0;
    case (c.action)
      bsr_pkg::ACT_LOAD_X: begin
        if (int'(c.vec_index) < n) begin
          x_mirror[c.vec_index] = $signed(c.value);
          x_loaded[c.vec_index] = 1'b1;
        end else begin
          err_mirror = 1'b1;
        end
        return 1'b0;
      end
      bsr_pkg::ACT_ACCUM: begin
        if (!elem_in_range(c, row, col)) begin
          err_mirror = 1'b1;
        end else begin
          prod = $signed(c.value) * $signed(x_mirror[col]);
          rnd  = (prod + 64'sd32768) >>> bsr_pkg::FRAC_W;
          sum  = $signed(y_mirror[row]) + rnd;
          if (sum > bsr_pkg::Y_MAX) sum = bsr_pkg::Y_MAX;
          if (sum < bsr_pkg::Y_MIN) sum = bsr_pkg::Y_MIN;
          y_mirror[row] = sum[bsr_pkg::Y_W-1:0];
        end
        return 1'b0;
      end
      bsr_pkg::ACT_READ_Y: begin
        res.row_index = c.vec_index;
        if (int'(c.vec_index) < n) begin
          res.y_value = y_mirror[c.vec_index];
          y_mirror[c.vec_index] = '0;
        end else begin
          err_mirror = 1'b1;
        end
        res.range_error = err_mirror;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic step_t t_cmd(bsr_pkg::action_t a, int br, int bc, int ri, int ci,
                                  int vi, logic [bsr_pkg::X_W-1:0] v);
    step_t s;
    s = '0;
    s.cmd.action       = a;
    s.cmd.blk_row      = bsr_pkg::BIDX_W'(br);
    s.cmd.block_col    = bsr_pkg::BIDX_W'(bc);
    s.cmd.row_in_block = bsr_pkg::OFS_W'(ri);
    s.cmd.col_in_block = bsr_pkg::OFS_W'(ci);
    s.cmd.vec_index    = bsr_pkg::VIDX_W'(vi);
    s.cmd.value        = v;
    return s;
  endfunction

  function automatic step_t t_read(int vi, bsr_pkg::yval_t y, logic e);
    step_t s;
    s = t_cmd(bsr_pkg::ACT_READ_Y, 0, 0, 0, 0, vi, '0);
    s.fixed            = 1'b1;
    s.want.row_index   = bsr_pkg::VIDX_W'(vi);
    s.want.y_value     = y;
    s.want.range_error = e;
    return s;
  endfunction

  function automatic step_t t_cfg(bsr_pkg::cfg_idx_t i, int d);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx    = i;
    s.data   = bsr_pkg::CFG_W'(d);
    return s;
  endfunction

  function automatic logic [bsr_pkg::X_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(0, 32'h3_FFFF)) - 32'h1_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_index(int n);
    if ($urandom_range(0, 1) == 1) return $urandom_range(0, ((n < 16) ? n : 16) - 1);
    return $urandom_range(0, n - 1);
  endfunction

  function automatic cmd_t gen_cmd();
    cmd_t c;
    int   n, rh, cw, row, col, pick;
    n  = eff_dim(num_rows_q, MAX_ROWS);
    rh = eff_dim(height_q, MAX_BLOCK_DIM);
    cw = eff_dim(width_q, MAX_BLOCK_DIM);
    c.action       = bsr_pkg::action_t'($urandom_range(0, 3));
    c.blk_row      = bsr_pkg::BIDX_W'($urandom);
    c.block_col    = bsr_pkg::BIDX_W'($urandom);
    c.row_in_block = bsr_pkg::OFS_W'($urandom);
    c.col_in_block = bsr_pkg::OFS_W'($urandom);
    c.vec_index    = bsr_pkg::VIDX_W'($urandom);
    c.value        = rand_value();
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      c.action    = bsr_pkg::ACT_LOAD_X;
      c.vec_index = bsr_pkg::VIDX_W'(pick_index(n));
    end else if (pick < 68) begin
      row = pick_index(n);
      col = $urandom_range(0, n - 1);
      c.action       = bsr_pkg::ACT_ACCUM;
      c.blk_row      = bsr_pkg::BIDX_W'(row / rh);
      c.row_in_block = bsr_pkg::OFS_W'(row % rh);
      c.block_col    = bsr_pkg::BIDX_W'(col / cw);
      c.col_in_block = bsr_pkg::OFS_W'(col % cw);
    end else if (pick < 88) begin
      c.action    = bsr_pkg::ACT_READ_Y;
      c.vec_index = bsr_pkg::VIDX_W'(pick_index(n));
    end
    // load the x entry first rather than read one never written
    if (c.action == bsr_pkg::ACT_ACCUM && elem_in_range(c, row, col) && !x_loaded[col]) begin
      c.action    = bsr_pkg::ACT_LOAD_X;
      c.vec_index = bsr_pkg::VIDX_W'(col);
    end
    return c;
  endfunction

  task automatic send_cmd(input cmd_t c, input logic fixed, input yread_t want,
                          input bit quiet);
    int     gap;
    yread_t got;
    bit     has;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 20) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    action       <= c.action;
    blk_row      <= c.blk_row;
    block_col    <= c.block_col;
    row_in_block <= c.row_in_block;
    col_in_block <= c.col_in_block;
    vec_index    <= c.vec_index;
    value        <= c.value;
    start        <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    has = apply_cmd(c, got);
    if (has) expected_reads.push_back(fixed ? want : got);
  endtask

  task automatic quiesce();
    start <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input bsr_pkg::cfg_idx_t idx,
                           input logic [bsr_pkg::CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      bsr_pkg::CFG_NUM_ROWS:     num_rows_q = data[bsr_pkg::NROWS_W-1:0];
      bsr_pkg::CFG_BLOCK_HEIGHT: height_q   = data[bsr_pkg::BDIM_W-1:0];
      bsr_pkg::CFG_BLOCK_WIDTH:  width_q    = data[bsr_pkg::BDIM_W-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : check_reads
    yread_t want;
    if (!rst && done) begin
      if (expected_reads.size() == 0) begin
        $display("%0t: unexpected result, row_index %0d y_value %0d", $time, row_index,
                 y_value);
        mismatches++;
      end else begin
        want = expected_reads.pop_front();
        if (row_index !== want.row_index) begin
          $display("%0t: row_index expected %0d actual %0d", $time, want.row_index,
                   row_index);
          mismatches++;
        end
        if (y_value !== want.y_value) begin
          $display("%0t: y_value expected %h actual %h", $time, want.y_value, y_value);
          mismatches++;
        end
        if (range_error !== want.range_error) begin
          $display("%0t: range_error expected %b actual %b", $time, want.range_error,
                   range_error);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    step_t  plan [$];
    cmd_t   c;
    yread_t none;
    none = '0;
    reset_mirror();

    plan.push_back(t_read(5, '0, 1'b0));
    plan.push_back(t_cmd(bsr_pkg::ACT_LOAD_X, 1023, 1023, 7, 7, 0, 32'h8000_0000));
    plan.push_back(t_cmd(bsr_pkg::ACT_LOAD_X, 0, 0, 0, 0, 1023, 32'h7FFF_FFFF));
    repeat (3) plan.push_back(t_cmd(bsr_pkg::ACT_ACCUM, 0, 0, 0, 0, 0, 32'h8000_0000));
    plan.push_back(t_read(0, bsr_pkg::Y_MAX, 1'b0));
    repeat (3) plan.push_back(t_cmd(bsr_pkg::ACT_ACCUM, 5, 1023, 0, 0, 1023, 32'h8000_0000));
    plan.push_back(t_read(5, bsr_pkg::Y_MIN, 1'b0));
    plan.push_back(t_cmd(bsr_pkg::ACT_LOAD_X, 0, 0, 0, 0, 1, 32'h0001_0000));
    plan.push_back(t_cmd(bsr_pkg::ACT_ACCUM, 1023, 1, 0, 0, 0, 32'hFFFE_8000));
    plan.push_back(t_cmd(ACT_RESERVED, 1023, 1023, 7, 7, 1023, 32'hFFFF_FFFF));
    plan.push_back(t_cmd(bsr_pkg::ACT_READ_Y, 1023, 1023, 7, 7, 1023, 32'hFFFF_FFFF));
    plan.push_back(t_cfg(bsr_pkg::CFG_NUM_ROWS, 16));
    plan.push_back(t_cfg(bsr_pkg::CFG_BLOCK_HEIGHT, 8));
    plan.push_back(t_cfg(bsr_pkg::CFG_BLOCK_WIDTH, 8));
    plan.push_back(t_cmd(bsr_pkg::ACT_LOAD_X, 0, 0, 0, 0, 15, 32'h1234_5678));
    plan.push_back(t_cmd(bsr_pkg::ACT_ACCUM, 1, 1, 7, 7, 0, 32'h0002_0000));
    plan.push_back(t_cmd(bsr_pkg::ACT_READ_Y, 0, 0, 0, 0, 15, '0));
    plan.push_back(t_cmd(bsr_pkg::ACT_ACCUM, 1, 1, 7, 7, 0, 32'h0002_0000));
    plan.push_back(t_cmd(bsr_pkg::ACT_ACCUM, 2, 0, 0, 0, 0, 32'h0001_0000));
    plan.push_back(t_cmd(bsr_pkg::ACT_ACCUM, 0, 2, 0, 0, 0, 32'h0001_0000));
    plan.push_back(t_read(1023, '0, 1'b1));
    plan.push_back(t_cmd(bsr_pkg::ACT_LOAD_X, 0, 0, 0, 0, 20, 32'h0001_0000));
    plan.push_back(t_cfg(bsr_pkg::CFG_BLOCK_HEIGHT, 0));
    plan.push_back(t_cfg(bsr_pkg::CFG_BLOCK_WIDTH, 15));
    plan.push_back(t_cmd(bsr_pkg::ACT_ACCUM, 0, 0, 3, 0, 0, 32'h0001_0000));
    plan.push_back(t_cfg(bsr_pkg::CFG_BLOCK_WIDTH, 0));
    plan.push_back(t_cmd(bsr_pkg::ACT_ACCUM, 0, 0, 0, 1, 0, 32'h0001_0000));
    plan.push_back(t_cmd(bsr_pkg::ACT_READ_Y, 0, 0, 0, 0, 15, '0));
    plan.push_back(t_cfg(bsr_pkg::CFG_NUM_ROWS, 0));
    plan.push_back(t_read(1, '0, 1'b1));
    plan.push_back(t_cmd(bsr_pkg::ACT_READ_Y, 0, 0, 0, 0, 0, '0));
    plan.push_back(t_cfg(bsr_pkg::CFG_NUM_ROWS, 2047));
    plan.push_back(t_cmd(bsr_pkg::ACT_READ_Y, 0, 0, 0, 0, 1023, '0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        quiesce();
        write_reg(plan[i].idx, plan[i].data);
        cfg_write <= 1'b0;
      end else begin
        send_cmd(plan[i].cmd, plan[i].fixed, plan[i].want, 1'b0);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      quiesce();
      write_reg(bsr_pkg::CFG_NUM_ROWS, bsr_pkg::CFG_W'(phase_rows[p]));
      write_reg(bsr_pkg::CFG_BLOCK_HEIGHT, bsr_pkg::CFG_W'(phase_height[p]));
      write_reg(bsr_pkg::CFG_BLOCK_WIDTH, bsr_pkg::CFG_W'(phase_width[p]));
      cfg_write <= 1'b0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        c = gen_cmd();
        send_cmd(c, 1'b0, none, p == 0);
      end
    end

    start <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
